@@ sv/upd_pkg.sv @@
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types and constants for the URL percent decoder with UTF-8 check.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

    // Longest string the decoded count tracks before it saturates.
    localparam int MAX_LEN   = 4096;
    localparam int COUNT_W   = 13;
    localparam int TALLY_CAP = (MAX_LEN < 8191) ? MAX_LEN : 8191;

    // Event queue between the decoder and the output register.
    localparam int MAX_EV  = 4;                      // events one byte can cause
    localparam int QDEPTH  = 8;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int EVN_W   = $clog2(MAX_EV + 1);

    typedef logic [QPTR_W-1:0] t_qptr;
    typedef logic [QCNT_W-1:0] t_qcnt;
    typedef logic [EVN_W-1:0]  t_evn;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ALLOW_CTRL = 2'd0;
    localparam logic [1:0] CFG_STOP_A     = 2'd1;
    localparam logic [1:0] CFG_STOP_B     = 2'd2;
    localparam logic [1:0] CFG_STOP_COUNT = 2'd3;

    // End causes.
    localparam logic [1:0] CAUSE_LAST = 2'd0;
    localparam logic [1:0] CAUSE_STOP = 2'd1;
    localparam logic [1:0] CAUSE_ZERO = 2'd2;

    // Characters.
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               byte_valid;
        logic               end_of_string;
        logic               utf8_valid;
        logic [1:0]         end_cause;
        logic [COUNT_W-1:0] decoded_count;
    } t_out;

    typedef struct packed {
        logic       allow_control_bytes;
        logic [7:0] stop_char_a;
        logic [7:0] stop_char_b;
        logic [1:0] stop_char_count;
    } t_cfg;

    // One queued event: a decoded byte or the end of a string.
    typedef struct packed {
        logic       is_end;
        logic [1:0] cause;
        logic [7:0] data;
    } t_evt;

    typedef struct packed {
        t_evt [MAX_EV-1:0] e;
        t_evn              n;
    } t_evlist;

    // Escape state of the decoder.
    typedef enum logic [1:0] {
        HELD_NONE,
        HELD_PCT,
        HELD_DIG
    } t_held;

endpackage

`default_nettype wire

@@ sv/upd_decode.sv @@
// ----------------------------------------------------------------------------
// upd_decode
// Per-byte percent decoder: escape state, stop handling, event list.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire upd_pkg::t_in    i_item,
    input  wire upd_pkg::t_cfg   i_cfg,
    output upd_pkg::t_evlist     o_evs
);
    import upd_pkg::*;

    typedef enum logic [1:0] {
        LK_EMIT,
        LK_HOLD,
        LK_END
    } t_lit_kind;

    typedef struct packed {
        t_lit_kind  kind;
        logic [1:0] cause;
        logic [7:0] data;
    } t_lit;

    function automatic logic is_hex(input logic [7:0] x);
        return x inside {[CH_0:CH_9], [CH_UA:CH_UF], [CH_LA:CH_LF]};
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] x);
        logic [7:0] t;
        if (x <= CH_9) begin
            t = x - CH_0;
        end else if (x <= CH_UF) begin
            t = x - CH_UA + 8'd10;
        end else begin
            t = x - CH_LA + 8'd10;
        end
        return t[3:0];
    endfunction

    // What a byte at a literal position does.
    function automatic t_lit classify(input logic [7:0] x, input t_cfg cfg);
        t_lit r;
        r.kind  = LK_EMIT;
        r.cause = CAUSE_LAST;
        r.data  = x;
        if (x == 8'h00) begin
            r.kind  = LK_END;
            r.cause = CAUSE_ZERO;
        end else if ((cfg.stop_char_count != 2'd0 && x == cfg.stop_char_a) ||
                     (cfg.stop_char_count >= 2'd2 && x == cfg.stop_char_b)) begin
            r.kind  = LK_END;
            r.cause = CAUSE_STOP;
        end else if (x == CH_PCT) begin
            r.kind = LK_HOLD;
        end else if (x == CH_PLUS) begin
            r.data = CH_SPACE;
        end
        return r;
    endfunction

    function automatic t_evlist push_evt(input t_evlist l, input t_evt e);
        t_evlist r;
        r = l;
        r.e[r.n[EVN_W-2:0]] = e;
        r.n = r.n + t_evn'(1);
        return r;
    endfunction

    function automatic t_evt byte_evt(input logic [7:0] b);
        t_evt e;
        e.is_end = 1'b0;
        e.cause  = CAUSE_LAST;
        e.data   = b;
        return e;
    endfunction

    function automatic t_evt end_evt(input logic [1:0] cause);
        t_evt e;
        e.is_end = 1'b1;
        e.cause  = cause;
        e.data   = 8'h00;
        return e;
    endfunction

    function automatic t_evlist push_lit(input t_evlist l, input t_lit x);
        t_evlist r;
        r = l;
        if (x.kind == LK_EMIT) begin
            r = push_evt(r, byte_evt(x.data));
        end else if (x.kind == LK_END) begin
            r = push_evt(r, end_evt(x.cause));
        end
        return r;
    endfunction

    t_held      r_held,    n_held;
    logic [7:0] r_dig,     n_dig;
    logic       r_stopped, n_stopped;

    t_lit       lit_c, lit_h;
    t_evlist    evs;
    logic       done;
    logic [7:0] dec_v;
    logic [7:0] raw;
    logic       last;

    always_comb begin
        raw   = i_item.raw_byte;
        last  = i_item.last_byte;
        lit_c = classify(raw, i_cfg);
        lit_h = classify(r_dig, i_cfg);

        dec_v = {hex_val(r_dig), hex_val(raw)};
        if (!i_cfg.allow_control_bytes) begin
            if (dec_v == CH_TAB) begin
                dec_v = CH_SPACE;
            end else if (dec_v < CH_SPACE) begin
                dec_v = CH_QMARK;
            end
        end

        evs       = '0;
        done      = 1'b0;
        n_held    = r_held;
        n_dig     = r_dig;
        n_stopped = r_stopped;

        if (r_stopped) begin
            if (last) begin
                n_stopped = 1'b0;
            end
        end else begin
            case (r_held)
                HELD_NONE: begin
                    evs    = push_lit(evs, lit_c);
                    done   = (lit_c.kind == LK_END);
                    n_held = (lit_c.kind == LK_HOLD) ? HELD_PCT : HELD_NONE;
                end
                HELD_PCT: begin
                    if (is_hex(raw)) begin
                        n_held = HELD_DIG;
                        n_dig  = raw;
                    end else begin
                        evs    = push_evt(evs, byte_evt(CH_PCT));
                        evs    = push_lit(evs, lit_c);
                        done   = (lit_c.kind == LK_END);
                        n_held = (lit_c.kind == LK_HOLD) ? HELD_PCT : HELD_NONE;
                    end
                end
                HELD_DIG: begin
                    if (is_hex(raw)) begin
                        evs    = push_evt(evs, byte_evt(dec_v));
                        n_held = HELD_NONE;
                    end else begin
                        // broken escape: '%' and the held digit go out literally
                        evs    = push_evt(evs, byte_evt(CH_PCT));
                        evs    = push_lit(evs, lit_h);
                        n_held = HELD_NONE;
                        if (lit_h.kind == LK_END) begin
                            done = 1'b1;
                        end else begin
                            evs    = push_lit(evs, lit_c);
                            done   = (lit_c.kind == LK_END);
                            n_held = (lit_c.kind == LK_HOLD) ? HELD_PCT : HELD_NONE;
                        end
                    end
                end
                default: begin
                    n_held = HELD_NONE;
                end
            endcase

            if (!done && last) begin
                // escape cut by the end of the string stays literal
                if (n_held != HELD_NONE) begin
                    evs = push_evt(evs, byte_evt(CH_PCT));
                    if (n_held == HELD_DIG) begin
                        // the digit was taken this cycle, so it is the raw byte
                        evs  = push_lit(evs, lit_c);
                        done = (lit_c.kind == LK_END);
                    end
                end
                n_held = HELD_NONE;
                if (!done) begin
                    evs = push_evt(evs, end_evt(CAUSE_LAST));
                end
            end else if (done && !last) begin
                n_stopped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= HELD_NONE;
            r_stopped <= 1'b0;
        end else if (i_accept) begin
            r_held    <= n_held;
            r_stopped <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_dig <= n_dig;
        end
    end

    assign o_evs = evs;

endmodule

`default_nettype wire

@@ sv/upd_utf8.sv @@
// ----------------------------------------------------------------------------
// upd_utf8
// UTF-8 shape/overlong tracker and decoded byte tally, one event per step.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_utf8 (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_step,
    input  wire upd_pkg::t_evt            i_evt,
    output logic                          o_utf8_valid,
    output logic [upd_pkg::COUNT_W-1:0]   o_count
);
    import upd_pkg::*;

    function automatic logic [20:0] min_code(input logic [1:0] cls);
        logic [20:0] r;
        case (cls)
            2'd1:    r = 21'h00080;
            2'd2:    r = 21'h00800;
            2'd3:    r = 21'h10000;
            default: r = 21'h00000;
        endcase
        return r;
    endfunction

    logic [1:0]         r_trail, n_trail;
    logic [1:0]         r_cls,   n_cls;
    logic [20:0]        r_acc,   n_acc;
    logic               r_ok,    n_ok;
    logic [COUNT_W-1:0] r_tally, n_tally;
    logic [7:0]         c;

    always_comb begin
        c       = i_evt.data;
        n_trail = r_trail;
        n_cls   = r_cls;
        n_acc   = r_acc;
        n_ok    = r_ok;
        n_tally = r_tally;

        if (i_evt.is_end) begin
            n_trail = 2'd0;
            n_cls   = 2'd0;
            n_acc   = '0;
            n_ok    = 1'b1;
            n_tally = '0;
        end else begin
            if (r_tally < COUNT_W'(TALLY_CAP)) begin
                n_tally = r_tally + COUNT_W'(1);
            end
            if (r_ok) begin
                if (!c[7]) begin
                    if (r_trail != 2'd0) n_ok = 1'b0;
                end else if (c[7:6] == 2'b10) begin
                    if (r_trail == 2'd0) begin
                        n_ok = 1'b0;
                    end else begin
                        n_acc   = {r_acc[14:0], c[5:0]};
                        n_trail = r_trail - 2'd1;
                        if (n_trail == 2'd0 && n_acc < min_code(r_cls)) n_ok = 1'b0;
                    end
                end else if (r_trail != 2'd0) begin
                    n_ok = 1'b0;
                end else if (c[7:5] == 3'b110) begin
                    n_trail = 2'd1;
                    n_cls   = 2'd1;
                    n_acc   = {16'd0, c[4:0]};
                end else if (c[7:4] == 4'b1110) begin
                    n_trail = 2'd2;
                    n_cls   = 2'd2;
                    n_acc   = {17'd0, c[3:0]};
                end else if (c[7:3] == 5'b11110) begin
                    n_trail = 2'd3;
                    n_cls   = 2'd3;
                    n_acc   = {18'd0, c[2:0]};
                end else begin
                    n_ok = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trail <= 2'd0;
            r_cls   <= 2'd0;
            r_acc   <= '0;
            r_ok    <= 1'b1;
            r_tally <= '0;
        end else if (i_step) begin
            r_trail <= n_trail;
            r_cls   <= n_cls;
            r_acc   <= n_acc;
            r_ok    <= n_ok;
            r_tally <= n_tally;
        end
    end

    // An unfinished sequence at the end of a string makes it invalid.
    assign o_utf8_valid = r_ok && (r_trail == 2'd0);
    assign o_count      = r_tally;

endmodule

`default_nettype wire

@@ sv/url_percent_decoder_utf8_check_core.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder_utf8_check_core
// URL percent decoder with UTF-8 validity check and per-string end report.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one raw URL byte
//   per transaction with a last-byte mark. Output channel (o_out_valid /
//   i_out_ready / o_out_data) gives decoded byte transactions and one end
//   transaction per string (UTF-8 validity, end cause, decoded count).
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
//   always ready; write it only while the block is idle.
// Timing:
//   A byte is decoded in the cycle it is accepted and its results go into an
//   8-entry event queue; the first result then moves into the output register,
//   from which it can be taken. While the receiver is ready, the output
//   register drains one result per cycle, so one byte per cycle is sustained
//   while bytes give at most one result each; a byte can give up to four
//   results, and o_in_ready drops while fewer than four queue slots are free.
// Reset (synchronous, active low): config registers clear, the queue empties,
//   escape/stop state and UTF-8 tracking restart. A stalled receiver holds the
//   output register; the queue absorbs bytes until it is nearly full.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder_utf8_check_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire upd_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output upd_pkg::t_out     o_out_data,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [7:0]   i_cfg_data
);
    import upd_pkg::*;

    // ---------------- configuration registers ----------------
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALLOW_CTRL: r_cfg.allow_control_bytes <= i_cfg_data[0];
                CFG_STOP_A:     r_cfg.stop_char_a         <= i_cfg_data;
                CFG_STOP_B:     r_cfg.stop_char_b         <= i_cfg_data;
                CFG_STOP_COUNT: r_cfg.stop_char_count     <= i_cfg_data[1:0];
                default:        r_cfg                     <= r_cfg;
            endcase
        end
    end

    // ---------------- decoder ----------------
    logic    in_accept;
    t_evlist evs;

    // Room for the worst case burst of one byte.
    t_qcnt r_cnt, n_cnt;
    assign o_in_ready = (r_cnt <= t_qcnt'(QDEPTH - MAX_EV));
    assign in_accept  = i_in_valid && o_in_ready;

    upd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_evs    (evs)
    );

    // ---------------- event queue ----------------
    // Multi-write ring: up to MAX_EV events enter per accepted byte, one leaves.
    t_evt  r_q [QDEPTH];
    t_qptr r_wr, r_rd;
    t_evn  push_n;
    logic  pop;
    t_evt  head;

    assign push_n = in_accept ? evs.n : t_evn'(0);
    assign pop    = (r_cnt != '0) && (!o_out_valid || i_out_ready);
    assign head   = r_q[r_rd];
    assign n_cnt  = r_cnt + t_qcnt'(push_n) - t_qcnt'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= '0;
            r_rd  <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_wr  <= r_wr + t_qptr'(push_n);
            if (pop) begin
                r_rd <= r_rd + t_qptr'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_EV; k++) begin
            if (t_evn'(k) < push_n) begin
                r_q[r_wr + t_qptr'(k)] <= evs.e[k];
            end
        end
    end

    // ---------------- UTF-8 tracking, updated as events leave ----------------
    logic               utf8_valid;
    logic [COUNT_W-1:0] tally;

    upd_utf8 u_utf8 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (pop),
        .i_evt        (head),
        .o_utf8_valid (utf8_valid),
        .o_count      (tally)
    );

    // ---------------- output register ----------------
    t_out r_out, n_out;
    logic r_out_valid;

    always_comb begin
        n_out = '0;
        if (head.is_end) begin
            n_out.end_of_string = 1'b1;
            n_out.utf8_valid    = utf8_valid;
            n_out.end_cause     = head.cause;
            n_out.decoded_count = tally;
        end else begin
            n_out.out_byte   = head.data;
            n_out.byte_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ sv/upd_checker.sv @@
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks for the URL decoder core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          o_out_valid,
    input  wire logic          i_out_ready,
    input  wire upd_pkg::t_out o_out_data
);
    import upd_pkg::*;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // Each transaction is either a byte or an end report, never both.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.byte_valid != o_out_data.end_of_string))
        else $error("transaction kind malformed");

    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.byte_valid |->
            (!o_out_data.utf8_valid && o_out_data.end_cause == CAUSE_LAST &&
             o_out_data.decoded_count == '0))
        else $error("byte transaction carries end fields");

endmodule

bind url_percent_decoder_utf8_check_core upd_checker u_upd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

@@ tb/url_percent_decoder_utf8_check_core_test.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder_utf8_check_core_test
// Self-checking bench for the URL percent decoder with UTF-8 check. A short
// table of directed bytes is followed by random URL strings under several
// stop-character and control-byte settings. Each decoded byte and end
// transaction is compared against a cycle-free decoder model kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module url_percent_decoder_utf8_check_core_test;
    import upd_pkg::*;

    localparam int RUN_LIMIT_NS  = 3_000_000;
    localparam int SETTLE_CYCLES = 8;       // queue plus output register, padded
    localparam int PHASE_ITEMS   = 30;      // per half phase

    typedef enum logic { ROW_BYTE, ROW_REG } t_row_kind;

    // One line of the directed table: a raw byte or a register write.
    typedef struct {
        t_row_kind  kind;
        logic [7:0] val;
        logic       last;
        logic [1:0] reg_idx;
        bit         has_typed;
        t_out       typed;
    } t_dir_row;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in        in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out       out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    bit idle_on = 1'b1;

    // Decoder model state
    t_cfg        dec_cfg;
    t_held       esc_state;
    logic [7:0]  esc_digit;
    bit          drop_rest;
    int          trail_cnt;
    logic [20:0] min_cp;
    logic [20:0] cp_acc;
    bit          utf_good;
    int          dec_tally;

    t_out     dec_step[$];      // results of the byte just decoded
    t_out     decoded_due[$];   // results still owed by the block
    t_in      raw_plan[$];      // raw bytes of the string being sent
    t_dir_row dir_rows[$];

    int fail_cnt      = 0;
    int items_taken   = 0;
    int results_seen  = 0;
    int strings_ended = 0;

    url_percent_decoder_utf8_check_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("url_percent_decoder_utf8_check_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    function automatic t_out mk_byte(input logic [7:0] b);
        t_out r;
        r = '0;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    function automatic t_out mk_end(input logic ok, input logic [1:0] cause,
                                    input logic [COUNT_W-1:0] cnt);
        t_out r;
        r = '0;
        r.end_of_string = 1'b1;
        r.utf8_valid    = ok;
        r.end_cause     = cause;
        r.decoded_count = cnt;
        return r;
    endfunction

    function automatic bit is_hexdig(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
               (c >= CH_LA && c <= CH_LF);
    endfunction

    function automatic logic [3:0] nibble(input logic [7:0] c);
        logic [7:0] d;
        if (c <= CH_9)
            d = c - CH_0;
        else if (c <= CH_UF)
            d = c - CH_UA + 8'd10;
        else
            d = c - CH_LA + 8'd10;
        return d[3:0];
    endfunction

    function automatic void string_restart();
        esc_state = HELD_NONE;
        trail_cnt = 0;
        min_cp    = '0;
        cp_acc    = '0;
        utf_good  = 1'b1;
        dec_tally = 0;
    endfunction

    // UTF-8 shape and overlong tracking over decoded bytes; sticky once bad.
    function automatic void utf8_follow(input logic [7:0] c);
        if (!utf_good)
            return;
        if (c[7] == 1'b0) begin
            if (trail_cnt > 0)
                utf_good = 1'b0;
        end else if (c[7:6] == 2'b10) begin
            if (trail_cnt == 0) begin
                utf_good = 1'b0;
            end else begin
                cp_acc = {cp_acc[14:0], c[5:0]};
                trail_cnt--;
                if (trail_cnt == 0 && cp_acc < min_cp)
                    utf_good = 1'b0;
            end
        end else if (trail_cnt > 0) begin
            utf_good = 1'b0;
        end else if (c[7:5] == 3'b110) begin
            trail_cnt = 1;
            min_cp    = 21'h80;
            cp_acc    = {16'd0, c[4:0]};
        end else if (c[7:4] == 4'b1110) begin
            trail_cnt = 2;
            min_cp    = 21'h800;
            cp_acc    = {17'd0, c[3:0]};
        end else if (c[7:3] == 5'b11110) begin
            trail_cnt = 3;
            min_cp    = 21'h10000;
            cp_acc    = {18'd0, c[2:0]};
        end else begin
            utf_good = 1'b0;
        end
    endfunction

    function automatic void emit_byte(input logic [7:0] c);
        dec_step.push_back(mk_byte(c));
        if (dec_tally < TALLY_CAP)
            dec_tally++;
        utf8_follow(c);
    endfunction

    function automatic void emit_end(input logic [1:0] cause);
        // an open sequence at the end spoils the string
        if (trail_cnt > 0)
            utf_good = 1'b0;
        dec_step.push_back(mk_end(utf_good, cause, dec_tally[COUNT_W-1:0]));
        string_restart();
    endfunction

    // Byte at a literal position; returns 1 when it ends the string.
    function automatic bit take_literal(input logic [7:0] c);
        if (c == 8'h00) begin
            emit_end(CAUSE_ZERO);
            return 1'b1;
        end
        if ((dec_cfg.stop_char_count >= 2'd1 && c == dec_cfg.stop_char_a) ||
            (dec_cfg.stop_char_count >= 2'd2 && c == dec_cfg.stop_char_b)) begin
            emit_end(CAUSE_STOP);
            return 1'b1;
        end
        if (c == CH_PCT)
            esc_state = HELD_PCT;
        else if (c == CH_PLUS)
            emit_byte(CH_SPACE);
        else
            emit_byte(c);
        return 1'b0;
    endfunction

    function automatic void decode_raw_byte(input t_in it);
        logic [7:0] c;
        logic [7:0] v;
        bit         done;
        bit         held_two;
        c    = it.raw_byte;
        done = 1'b0;
        if (drop_rest) begin
            if (it.last_byte)
                drop_rest = 1'b0;
            return;
        end
        case (esc_state)
            HELD_NONE: begin
                done = take_literal(c);
            end
            HELD_PCT: begin
                if (is_hexdig(c)) begin
                    esc_digit = c;
                    esc_state = HELD_DIG;
                end else begin
                    esc_state = HELD_NONE;
                    emit_byte(CH_PCT);
                    done = take_literal(c);
                end
            end
            default: begin
                esc_state = HELD_NONE;
                if (is_hexdig(c)) begin
                    v = {nibble(esc_digit), nibble(c)};
                    if (!dec_cfg.allow_control_bytes) begin
                        if (v == CH_TAB)
                            v = CH_SPACE;
                        else if (v < CH_SPACE)
                            v = CH_QMARK;
                    end
                    emit_byte(v);
                end else begin
                    // broken escape: '%' goes out, held digit and this byte re-run
                    emit_byte(CH_PCT);
                    done = take_literal(esc_digit);
                    if (!done)
                        done = take_literal(c);
                end
            end
        endcase
        if (done) begin
            if (!it.last_byte)
                drop_rest = 1'b1;
            return;
        end
        if (it.last_byte) begin
            // escape cut by the last mark stays literal
            if (esc_state != HELD_NONE) begin
                held_two  = (esc_state == HELD_DIG);
                esc_state = HELD_NONE;
                emit_byte(CH_PCT);
                if (held_two)
                    done = take_literal(esc_digit);
            end
            if (!done)
                emit_end(CAUSE_LAST);
        end
    endfunction

    // ------------------------------------------------------------------------
    // String builder for the random part
    // ------------------------------------------------------------------------
    function automatic void plan_byte(input logic [7:0] b);
        t_in t;
        t.raw_byte  = b;
        t.last_byte = 1'b0;
        raw_plan.push_back(t);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] base;
        if (n < 4'd10)
            return CH_0 + n;
        base = $urandom_range(0, 1) ? CH_UA : CH_LA;
        return base + n - 8'd10;
    endfunction

    function automatic void plan_escape(input logic [7:0] v);
        plan_byte(CH_PCT);
        plan_byte(hex_char(v[7:4]));
        plan_byte(hex_char(v[3:0]));
    endfunction

    function automatic void plan_enc(input logic [7:0] b);
        if ($urandom_range(0, 1))
            plan_escape(b);
        else
            plan_byte(b);
    endfunction

    // Multi-byte character, sometimes overlong, sometimes missing its tail.
    function automatic void plan_utf8();
        int          n;
        int          cut;
        int unsigned lo;
        int unsigned hi;
        logic [20:0] cp;
        logic [20:0] sh;
        logic [7:0]  b;
        n  = $urandom_range(2, 4);
        lo = (n == 2) ? 32'h80 : (n == 3) ? 32'h800 : 32'h10000;
        hi = (n == 2) ? 32'h7FF : (n == 3) ? 32'hFFFF : 32'h1FFFFF;
        if ($urandom_range(0, 7) == 0)
            cp = 21'($urandom_range(0, lo - 1));
        else
            cp = 21'($urandom_range(lo, hi));
        cut = ($urandom_range(0, 7) == 0) ? 1 : 0;
        case (n)
            2:       b = {3'b110, cp[10:6]};
            3:       b = {4'b1110, cp[15:12]};
            default: b = {5'b11110, cp[20:18]};
        endcase
        plan_enc(b);
        for (int k = n - 2; k >= cut; k--) begin
            sh = cp >> (6 * k);
            plan_enc({2'b10, sh[5:0]});
        end
    endfunction

    function automatic void seal_plan();
        t_in tail;
        tail = raw_plan.pop_back();
        tail.last_byte = 1'b1;
        raw_plan.push_back(tail);
    endfunction

    function automatic void build_string();
        int         n_tok;
        int         i;
        int         sel;
        bit         noise;
        logic [7:0] b;
        raw_plan.delete();
        n_tok = $urandom_range(1, 12);
        noise = ($urandom_range(0, 9) == 0);
        i = 0;
        while (i < n_tok) begin
            sel = $urandom_range(0, 99);
            if (noise || sel >= 88) begin
                plan_byte(8'($urandom_range(0, 255)));
            end else if (sel < 30) begin
                plan_byte(8'($urandom_range(8'h20, 8'h7E)));
            end else if (sel < 45) begin
                // low values stress the control-byte mapping
                plan_escape(sel < 40 ? 8'($urandom_range(0, 255))
                                     : 8'($urandom_range(0, 8'h20)));
            end else if (sel < 60) begin
                plan_utf8();
            end else if (sel < 68) begin
                plan_byte(CH_PLUS);
            end else if (sel < 78) begin
                // broken escape, or one cut short by the end of the string
                plan_byte(CH_PCT);
                if ($urandom_range(0, 1))
                    plan_byte(hex_char(4'($urandom_range(0, 15))));
                if ($urandom_range(0, 3) == 0) begin
                    i = n_tok;
                end else begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (is_hexdig(b));
                    plan_byte(b);
                end
            end else if (sel < 84) begin
                plan_byte($urandom_range(0, 1) ? dec_cfg.stop_char_a : dec_cfg.stop_char_b);
            end else begin
                plan_byte(8'h00);
            end
            i++;
        end
        seal_plan();
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers (inputs change on the falling edge)
    // ------------------------------------------------------------------------
    task automatic push_byte(input t_in it, input bit has_typed = 1'b0,
                             input t_out typed = '0);
        int gap;
        bit ignored;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        ignored = drop_rest;
        dec_step.delete();
        decode_raw_byte(it);
        if (has_typed)
            decoded_due.push_back(typed);
        else
            foreach (dec_step[k])
                decoded_due.push_back(dec_step[k]);
        if (!ignored)
            items_taken++;
    endtask

    // Hold the sender off until every owed result is out, then let the
    // block settle in case a held escape is still in flight.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ALLOW_CTRL: dec_cfg.allow_control_bytes = val[0];
            CFG_STOP_A:     dec_cfg.stop_char_a         = val;
            CFG_STOP_B:     dec_cfg.stop_char_b         = val;
            CFG_STOP_COUNT: dec_cfg.stop_char_count     = val[1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input t_cfg c);
        write_reg(CFG_ALLOW_CTRL, {7'd0, c.allow_control_bytes});
        write_reg(CFG_STOP_A, c.stop_char_a);
        write_reg(CFG_STOP_B, c.stop_char_b);
        write_reg(CFG_STOP_COUNT, {6'd0, c.stop_char_count});
    endtask

    task automatic run_strings(input int want);
        int start;
        start = items_taken;
        while (items_taken - start < want) begin
            build_string();
            foreach (raw_plan[k])
                push_byte(raw_plan[k]);
        end
    endtask

    function automatic void add_byte_row(input logic [7:0] b, input logic last,
                                         input bit has_typed = 1'b0,
                                         input t_out typed = '0);
        t_dir_row r;
        r.kind      = ROW_BYTE;
        r.val       = b;
        r.last      = last;
        r.reg_idx   = '0;
        r.has_typed = has_typed;
        r.typed     = typed;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_reg_row(input logic [1:0] idx, input logic [7:0] val);
        t_dir_row r;
        r.kind      = ROW_REG;
        r.val       = val;
        r.last      = 1'b0;
        r.reg_idx   = idx;
        r.has_typed = 1'b0;
        r.typed     = '0;
        dir_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver pacing: random stall bursts while idling is on
    // ------------------------------------------------------------------------
    initial begin : out_pacing
        int stall;
        stall = 0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 6) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [12:0] want,
                                        input logic [12:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk) begin : out_check
        t_out want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            results_seen++;
            if (decoded_due.size() == 0) begin
                $error("result with nothing owed: byte %0h end %0b",
                       out_item.out_byte, out_item.end_of_string);
                fail_cnt++;
            end else begin
                want = decoded_due.pop_front();
                if (want.end_of_string)
                    strings_ended++;
                check_field("out_byte", COUNT_W'(want.out_byte),
                            COUNT_W'(out_item.out_byte));
                check_field("byte_valid", COUNT_W'(want.byte_valid),
                            COUNT_W'(out_item.byte_valid));
                check_field("end_of_string", COUNT_W'(want.end_of_string),
                            COUNT_W'(out_item.end_of_string));
                check_field("utf8_valid", COUNT_W'(want.utf8_valid),
                            COUNT_W'(out_item.utf8_valid));
                check_field("end_cause", COUNT_W'(want.end_cause),
                            COUNT_W'(out_item.end_cause));
                check_field("decoded_count", want.decoded_count, out_item.decoded_count);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_cfg phase_cfg[5];
        t_in  it;

        dec_cfg   = '0;
        drop_rest = 1'b0;
        esc_digit = '0;
        string_restart();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: safe mode, no stop characters.
        add_byte_row(CH_PLUS, 1'b0, 1'b1, mk_byte(CH_SPACE));
        add_byte_row(CH_PCT, 1'b0);
        add_byte_row(CH_0, 1'b0);
        add_byte_row(CH_9, 1'b0, 1'b1, mk_byte(CH_SPACE));     // tab turns into space
        add_byte_row(CH_PCT, 1'b0);
        add_byte_row(CH_0, 1'b0);
        add_byte_row(CH_0, 1'b0, 1'b1, mk_byte(CH_QMARK));     // decoded zero, safe mode
        add_byte_row(8'hFF, 1'b0, 1'b1, mk_byte(8'hFF));
        add_byte_row(CH_PCT, 1'b0);
        add_byte_row(CH_UA, 1'b1);                             // escape cut after digit
        add_byte_row(8'h00, 1'b0, 1'b1, mk_end(1'b1, CAUSE_ZERO, 13'd0));
        add_byte_row(8'hFF, 1'b0);                             // dropped after stop
        add_byte_row(8'hFF, 1'b1);
        add_byte_row(CH_PCT, 1'b1);                            // lone '%' at the end
        // Controls kept, stop on '4', zero as second stop, count of three.
        add_reg_row(CFG_ALLOW_CTRL, 8'd1);
        add_reg_row(CFG_STOP_A, 8'h34);
        add_reg_row(CFG_STOP_B, 8'h00);
        add_reg_row(CFG_STOP_COUNT, 8'd3);
        add_byte_row(CH_PCT, 1'b0);
        add_byte_row(CH_0, 1'b0);
        add_byte_row(CH_0, 1'b0, 1'b1, mk_byte(8'h00));        // decoded zero, kept
        add_byte_row(CH_PCT, 1'b0);
        add_byte_row(8'h34, 1'b0);                             // stop char as escape digit
        add_byte_row(8'h31, 1'b0);
        add_byte_row(CH_PCT, 1'b0);
        add_byte_row(8'h34, 1'b0);
        add_byte_row(8'h78, 1'b0);                             // held digit re-run, stops
        add_byte_row(8'h71, 1'b1);
        add_byte_row(8'h34, 1'b1, 1'b1, mk_end(1'b1, CAUSE_STOP, 13'd0));
        add_byte_row(8'h62, 1'b1);                             // nothing dropped after that
        add_byte_row(8'h00, 1'b1, 1'b1, mk_end(1'b1, CAUSE_ZERO, 13'd0));
        add_byte_row(8'hC0, 1'b0);                             // overlong two-byte form
        add_byte_row(8'h80, 1'b1);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_REG) begin
                write_reg(dir_rows[k].reg_idx, dir_rows[k].val);
            end else begin
                it.raw_byte  = dir_rows[k].val;
                it.last_byte = dir_rows[k].last;
                push_byte(it, dir_rows[k].has_typed, dir_rows[k].typed);
            end
        end

        phase_cfg[0] = '{1'b0, 8'h00, 8'h00, 2'd0};
        phase_cfg[1] = '{1'b1, 8'hFF, 8'h26, 2'd2};
        phase_cfg[2] = '{1'b0, 8'h3D, 8'hFF, 2'd1};
        phase_cfg[3].allow_control_bytes = 1'($urandom_range(0, 1));
        phase_cfg[3].stop_char_a         = 8'($urandom_range(0, 255));
        phase_cfg[3].stop_char_b         = 8'($urandom_range(0, 255));
        phase_cfg[3].stop_char_count     = 2'($urandom_range(0, 3));
        phase_cfg[4] = '{1'b1, 8'h23, 8'h26, 2'd3};

        for (int p = 0; p < 5; p++) begin
            idle_on = (p < 4);
            set_config(phase_cfg[p]);
            run_strings(PHASE_ITEMS);
            drain();                                           // sender waits it out
            run_strings(PHASE_ITEMS);
        end

        drain();

        $display("covered %0d decoded input bytes, %0d results, %0d strings closed",
                 items_taken, results_seen, strings_ended);
        $display("directed table, then random strings under five register settings");
        if (fail_cnt == 0)
            $display("url_percent_decoder_utf8_check_core: match");
        else
            $display("url_percent_decoder_utf8_check_core: mismatch");
        $finish;
    end

endmodule

@@ url_percent_decoder_utf8_check_core.f @@
sv/upd_pkg.sv
sv/upd_decode.sv
sv/upd_utf8.sv
sv/url_percent_decoder_utf8_check_core.sv
sv/upd_checker.sv
tb/url_percent_decoder_utf8_check_core_test.sv
